/* sv/fdd_pkg.sv */
// ----------------------------------------------------------------------------
// fdd_pkg: shared types and constants of the finite-difference differentiator
// holds the sample task passed from the front end to the back end, the
// result kinds, the register indexes and the saturation helper
// ----------------------------------------------------------------------------
package fdd_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int RECIP_W     = 32;
   localparam int POINT_W     = 16;
   localparam int DERIV_W     = 48;
   // numerators reach about 2^26 in magnitude
   localparam int NUM_W       = 28;
   localparam int PROD_W      = NUM_W + RECIP_W + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_IDX_W   = 8;

   localparam logic [CSR_IDX_W-1:0] REG_INV_TWO_STEP     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_INV_STEP_SQUARED = CSR_IDX_W'(1);
   localparam logic [RECIP_W-1:0]   RECIP_RESET          = RECIP_W'(65536);
   localparam logic [POINT_W-1:0]   POINT_MAX            = {POINT_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_FIRST,
      KIND_MID,
      KIND_END,
      KIND_SHORT
   } kind_type;

   // one accepted sample that causes at least one result
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] a;
      logic signed [SAMPLE_W-1:0] b;
      logic signed [SAMPLE_W-1:0] c;
      logic [POINT_W-1:0]         idx_mid;
      logic [POINT_W-1:0]         idx_end;
      logic                       first_pt;
      logic                       last_pt;
      logic                       too_short;
   } task_type;

   typedef struct packed {
      logic [RECIP_W-1:0] inv_two_step;
      logic [RECIP_W-1:0] inv_step_squared;
   } cfg_type;

   function automatic logic [DERIV_W-1:0] sat48(input logic signed [PROD_W-1:0] p);
      logic hi_same;
      hi_same = (p[PROD_W-1:DERIV_W-1] == {(PROD_W-DERIV_W+1){1'b0}}) ||
                (p[PROD_W-1:DERIV_W-1] == {(PROD_W-DERIV_W+1){1'b1}});
      if (hi_same) begin
         return p[DERIV_W-1:0];
      end else if (p[PROD_W-1]) begin
         return {1'b1, {(DERIV_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DERIV_W-1){1'b1}}};
      end
   endfunction

endpackage

/* sv/fdd_front.sv */
// ----------------------------------------------------------------------------
// fdd_front: sample intake
// keeps the window and the run count and turns each sample that causes
// results into one task for the back end
// ----------------------------------------------------------------------------
module fdd_front #(
   parameter int INDEX_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [fdd_pkg::SAMPLE_W-1:0] sample,
   input  logic                      last_sample,
   output logic                      push,
   output fdd_pkg::task_type         push_task
);
   import fdd_pkg::*;

   localparam int IDX_EXT_W = (INDEX_WIDTH > POINT_W) ? INDEX_WIDTH : POINT_W;

   logic signed [SAMPLE_W-1:0] win_ff [2];
   logic signed [SAMPLE_W-1:0] win_in [2];
   logic [INDEX_WIDTH-1:0]     count_ff, count_in;
   logic                       early;
   logic [IDX_EXT_W-1:0]       mid_ext, end_ext;

   assign early   = count_ff < INDEX_WIDTH'(2);
   assign mid_ext = IDX_EXT_W'(count_ff) - IDX_EXT_W'(1);
   assign end_ext = IDX_EXT_W'(count_ff);

   always_comb begin
      push_task.a         = win_ff[0];
      push_task.b         = win_ff[1];
      push_task.c         = signed'(sample);
      push_task.idx_mid   = (mid_ext > IDX_EXT_W'(POINT_MAX)) ? POINT_MAX
                                                              : mid_ext[POINT_W-1:0];
      push_task.idx_end   = (end_ext > IDX_EXT_W'(POINT_MAX)) ? POINT_MAX
                                                              : end_ext[POINT_W-1:0];
      push_task.first_pt  = count_ff == INDEX_WIDTH'(2);
      push_task.last_pt   = last_sample;
      push_task.too_short = early;
   end

   assign push = take && (!early || last_sample);

   always_comb begin
      win_in   = win_ff;
      count_in = count_ff;
      if (take) begin
         if (last_sample) begin
            win_in[0] = '0;
            win_in[1] = '0;
            count_in  = '0;
         end else begin
            win_in[0] = win_ff[1];
            win_in[1] = signed'(sample);
            if (count_ff != {INDEX_WIDTH{1'b1}}) begin
               count_in = count_ff + INDEX_WIDTH'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[0] <= '0;
         win_ff[1] <= '0;
         count_ff  <= '0;
      end else begin
         win_ff   <= win_in;
         count_ff <= count_in;
      end
   end

endmodule

/* sv/fdd_queue.sv */
// ----------------------------------------------------------------------------
// fdd_queue: task queue
// short first-in first-out buffer between front end and back end
// ----------------------------------------------------------------------------
module fdd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fdd_pkg::task_type push_task,
   input  logic              pop,
   output fdd_pkg::task_type head_task,
   output logic              empty,
   output logic              full
);
   import fdd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   task_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     fill_ff, fill_in;

   assign empty     = fill_ff == '0;
   assign full      = fill_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign head_task = slot_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_task;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

endmodule

/* sv/fdd_back.sv */
// ----------------------------------------------------------------------------
// fdd_back: derivative pipeline
// expands each task into its results, forms the numerators, scales them by
// the reciprocals, saturates and holds the result for the output transfer
// ----------------------------------------------------------------------------
module fdd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  fdd_pkg::cfg_type              cfg,
   input  fdd_pkg::task_type             head_task,
   input  logic                          empty,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [fdd_pkg::POINT_W-1:0]   out_index,
   output logic [fdd_pkg::DERIV_W-1:0]   out_first,
   output logic [fdd_pkg::DERIV_W-1:0]   out_second,
   output logic                          out_second_valid,
   output logic                          out_too_short,
   output logic                          out_last
);
   import fdd_pkg::*;

   logic     adv, issue;
   kind_type kind;
   logic     done_first_ff, done_first_in, done_mid_ff, done_mid_in;

   logic signed [NUM_W-1:0] a_e, b_e, c_e, num1_in, num2_in;
   logic [POINT_W-1:0]      idx_in;

   // stage 1: numerators
   logic                    v1_ff;
   logic signed [NUM_W-1:0] num1_ff, num2_ff;
   logic [POINT_W-1:0]      idx1_ff;
   logic                    sv1_ff, sh1_ff, last1_ff;

   // stage 2: products
   logic                     v2_ff;
   logic signed [PROD_W-1:0] prod1_ff, prod2_ff;
   logic signed [PROD_W-1:0] prod1_in, prod2_in;
   logic signed [RECIP_W:0]  recip1, recip2;
   logic [POINT_W-1:0]       idx2_ff;
   logic                     sv2_ff, sh2_ff, last2_ff;

   // stage 3: output register
   logic                     out_valid_ff;
   logic [POINT_W-1:0]       out_index_ff;
   logic [DERIV_W-1:0]       out_first_ff, out_second_ff;
   logic                     out_sv_ff, out_sh_ff, out_last_ff;

   assign adv   = !out_valid_ff || out_ready;
   assign issue = adv && !empty;

   always_comb begin
      priority if (head_task.too_short) begin
         kind = KIND_SHORT;
      end else if (head_task.first_pt && !done_first_ff) begin
         kind = KIND_FIRST;
      end else if (!done_mid_ff) begin
         kind = KIND_MID;
      end else begin
         kind = KIND_END;
      end
   end

   assign pop = issue && ((kind == KIND_SHORT) || (kind == KIND_END) ||
                          ((kind == KIND_MID) && !head_task.last_pt));

   always_comb begin
      done_first_in = done_first_ff;
      done_mid_in   = done_mid_ff;
      if (pop) begin
         done_first_in = 1'b0;
         done_mid_in   = 1'b0;
      end else if (issue) begin
         if (kind == KIND_FIRST) begin
            done_first_in = 1'b1;
         end
         if (kind == KIND_MID) begin
            done_mid_in = 1'b1;
         end
      end
   end

   assign a_e = NUM_W'(head_task.a);
   assign b_e = NUM_W'(head_task.b);
   assign c_e = NUM_W'(head_task.c);

   always_comb begin
      num1_in = '0;
      num2_in = '0;
      idx_in  = '0;
      unique case (kind)
         KIND_FIRST: begin
            num1_in = (b_e <<< 2) - a_e - (a_e <<< 1) - c_e;
         end
         KIND_MID: begin
            num1_in = c_e - a_e;
            num2_in = c_e - (b_e <<< 1) + a_e;
            idx_in  = head_task.idx_mid;
         end
         KIND_END: begin
            num1_in = c_e + (c_e <<< 1) - (b_e <<< 2) + a_e;
            idx_in  = head_task.idx_end;
         end
         KIND_SHORT: begin
            num1_in = '0;
         end
      endcase
   end

   assign recip1   = signed'({1'b0, cfg.inv_two_step});
   assign recip2   = signed'({1'b0, cfg.inv_step_squared});
   assign prod1_in = num1_ff * recip1;
   assign prod2_in = num2_ff * recip2;

   always_ff @(posedge clock) begin
      if (adv) begin
         num1_ff       <= num1_in;
         num2_ff       <= num2_in;
         idx1_ff       <= idx_in;
         sv1_ff        <= kind == KIND_MID;
         sh1_ff        <= kind == KIND_SHORT;
         last1_ff      <= (kind == KIND_SHORT) || (kind == KIND_END);
         prod1_ff      <= prod1_in;
         prod2_ff      <= prod2_in;
         idx2_ff       <= idx1_ff;
         sv2_ff        <= sv1_ff;
         sh2_ff        <= sh1_ff;
         last2_ff      <= last1_ff;
         out_index_ff  <= idx2_ff;
         out_first_ff  <= sat48(prod1_ff);
         out_second_ff <= sat48(prod2_ff);
         out_sv_ff     <= sv2_ff;
         out_sh_ff     <= sh2_ff;
         out_last_ff   <= last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         out_valid_ff  <= 1'b0;
         done_first_ff <= 1'b0;
         done_mid_ff   <= 1'b0;
      end else begin
         done_first_ff <= done_first_in;
         done_mid_ff   <= done_mid_in;
         if (adv) begin
            v1_ff        <= issue;
            v2_ff        <= v1_ff;
            out_valid_ff <= v2_ff;
         end
      end
   end

   assign out_valid        = out_valid_ff;
   assign out_index        = out_index_ff;
   assign out_first        = out_first_ff;
   assign out_second       = out_second_ff;
   assign out_second_valid = out_sv_ff;
   assign out_too_short    = out_sh_ff;
   assign out_last         = out_last_ff;

endmodule

/* sv/finite_difference_differentiator.sv */
// ----------------------------------------------------------------------------
// finite_difference_differentiator: three-point derivative of a sample run
// front end takes samples, a task queue decouples it from the multiply
// pipeline that forms and saturates the derivative results
// ----------------------------------------------------------------------------
// Takes one signed Q8.16 sample per cycle (tlast marks the end of a run) and
// emits one result per grid point: the first derivative in Q16.32 (one-sided
// three-point formula at both ends, central difference inside), and inside
// the run also the second derivative. The first two samples of a run give no
// result, the third gives two (three when it also ends the run), a later last
// sample gives two; a run of one or two samples gives a single result with
// run_too_short set. Results leave at most one per cycle through a
// three-stage back end (numerator, multiply, saturate); a result issued from
// the head of the four-entry task queue passes the numerator, product and
// output registers before it appears. Sustained rate is one sample per cycle
// while rsp_tready is high and the queue has room, set by the single
// multiply pipeline; the extra results at each run's end are taken up by the
// queue, which holds req_tready low only when it is full.
// Configuration registers (index 0: 1/(2h), index 1: 1/h^2, unsigned Q16.16, both
// 1.0 after reset): the user must write them only while the block is idle; the block does not check this.
// ----------------------------------------------------------------------------
module finite_difference_differentiator #(
   parameter int INDEX_WIDTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   // sample channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [23:0]   req_tdata,   // sample
   input  logic          req_tlast,   // last sample of the run
   // result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,   // point_index, first_deriv, second_deriv
   output logic [1:0]    rsp_tuser,   // second_valid, run_too_short
   output logic          rsp_tlast,   // last result of the run
   // register write channel
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [7:0]    csr_index,
   input  logic [31:0]   csr_data
);
   import fdd_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   task_type push_task, head_task;
   logic     take, push, pop, empty, full;

   logic [POINT_W-1:0] out_index;
   logic [DERIV_W-1:0] out_first, out_second;
   logic               out_second_valid, out_too_short;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_INV_TWO_STEP:     cfg_in.inv_two_step     = csr_data;
            REG_INV_STEP_SQUARED: cfg_in.inv_step_squared = csr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_two_step     <= RECIP_RESET;
         cfg_ff.inv_step_squared <= RECIP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a sample is taken whenever the queue has room for its task
   assign req_tready = !full;
   assign take       = req_tvalid && req_tready;

   fdd_front #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .sample      (req_tdata),
      .last_sample (req_tlast),
      .push        (push),
      .push_task   (push_task)
   );

   fdd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_task (push_task),
      .pop       (pop),
      .head_task (head_task),
      .empty     (empty),
      .full      (full)
   );

   fdd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_task        (head_task),
      .empty            (empty),
      .pop              (pop),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_index        (out_index),
      .out_first        (out_first),
      .out_second       (out_second),
      .out_second_valid (out_second_valid),
      .out_too_short    (out_too_short),
      .out_last         (rsp_tlast)
   );

   // result fields packed from the lowest bit up
   assign rsp_tdata = {out_second, out_first, out_index};
   assign rsp_tuser = {out_too_short, out_second_valid};

endmodule
